### design/calib_record_validator_assert.svh
// ----------------------------------------------------------------------------
// Calibration record validator assertion macros
// Shared concurrent assertion forms used by the validator modules.
// ----------------------------------------------------------------------------
`ifndef CALIB_RECORD_VALIDATOR_ASSERT_SVH
`define CALIB_RECORD_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CRV_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("calib_record_validator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CRV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("calib_record_validator: next-cycle check failed");

`endif

### design/crv_pkg.sv
// ----------------------------------------------------------------------------
// Calibration record validator package
// Types, codes, layout constants and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package crv_pkg;

    // Payload lengths of the two record layouts
    localparam int CURRENT_PAYLOAD_BYTES = 40;
    localparam int OLD_PAYLOAD_BYTES     = 28;

    // Record layout
    localparam int MAGIC_BYTES  = 4;
    localparam int HEADER_BYTES = 8;
    localparam int CRC_BYTES    = 4;

    localparam logic [31:0] OLD_VERSION   = 32'd1;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [31:0] VERSION_RESET = 32'd2;

    // APB register map
    localparam int ADDR_W = 3;

    typedef enum logic {
        REG_RECORD_MAGIC    = 1'b0,
        REG_CURRENT_VERSION = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        VERDICT_CURRENT  = 2'd0,
        VERDICT_MIGRATE  = 2'd1,
        VERDICT_DEFAULTS = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC     = 2'd3
    } phase_t;

    typedef struct packed {
        logic [31:0] record_magic;
        logic [31:0] current_version;
    } cfg_t;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       record_start;
    } item_t;

    // One byte through the reflected CRC-32, a bit per step
    function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/crv_cfg_regs.sv
// ----------------------------------------------------------------------------
// Calibration record validator configuration registers
// APB-style register file holding the expected magic and current version.
// ----------------------------------------------------------------------------
module crv_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crv_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output crv_pkg::cfg_t               cfg
);

    crv_pkg::cfg_t      cfg_reg;
    crv_pkg::reg_index_t idx;
    logic               wr_en;

    assign idx    = crv_pkg::reg_index_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.record_magic    <= crv_pkg::MAGIC_RESET;
            cfg_reg.current_version <= crv_pkg::VERSION_RESET;
        end else if (wr_en) begin
            unique case (idx)
                crv_pkg::REG_RECORD_MAGIC:    cfg_reg.record_magic    <= pwdata;
                crv_pkg::REG_CURRENT_VERSION: cfg_reg.current_version <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            crv_pkg::REG_RECORD_MAGIC:    prdata = cfg_reg.record_magic;
            crv_pkg::REG_CURRENT_VERSION: prdata = cfg_reg.current_version;
            default:                      prdata = '0;
        endcase
    end

endmodule

### design/crv_input_stage.sv
// ----------------------------------------------------------------------------
// Calibration record validator input stage
// Registers one incoming word and holds it until the checker takes it.
// ----------------------------------------------------------------------------
`include "calib_record_validator_assert.svh"

module crv_input_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_record_byte,
    input  logic           s_record_start,
    output logic           item_valid,
    output crv_pkg::item_t item,
    input  logic           item_take
);

    logic           valid_reg;
    logic           valid_next;
    crv_pkg::item_t item_reg;

    // Free when empty or when the held word leaves this cycle
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on acceptance
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.record_byte  <= s_record_byte;
            item_reg.record_start <= s_record_start;
        end
    end

    // A held word that is not taken stays put
    `CRV_ASSERT_NEXT(a_hold_untaken, aclk, aresetn, valid_reg && !item_take, valid_reg && $stable(item_reg))

endmodule

### design/crv_record_check.sv
// ----------------------------------------------------------------------------
// Calibration record validator record checker
// Walks header, payload and stored CRC a byte at a time and registers
// the verdict.
// ----------------------------------------------------------------------------
`include "calib_record_validator_assert.svh"

module crv_record_check #(
    parameter int CURRENT_PAYLOAD_BYTES = crv_pkg::CURRENT_PAYLOAD_BYTES,
    parameter int OLD_PAYLOAD_BYTES     = crv_pkg::OLD_PAYLOAD_BYTES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  crv_pkg::cfg_t  cfg,
    input  logic           item_valid,
    input  crv_pkg::item_t item,
    output logic           item_take,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_verdict,
    output logic [31:0]    m_payload_crc
);

    localparam int MAX_PAY = (CURRENT_PAYLOAD_BYTES > OLD_PAYLOAD_BYTES) ?
                             CURRENT_PAYLOAD_BYTES : OLD_PAYLOAD_BYTES;
    localparam int MAX_CNT = (MAX_PAY > crv_pkg::HEADER_BYTES) ?
                             MAX_PAY : crv_pkg::HEADER_BYTES;
    localparam int CNT_W   = $clog2(MAX_CNT + 1);

    localparam logic [CNT_W-1:0] CUR_LEN   = CNT_W'(CURRENT_PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0] OLD_LEN   = CNT_W'(OLD_PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0] MAGIC_END = CNT_W'(crv_pkg::MAGIC_BYTES);
    localparam logic [CNT_W-1:0] HDR_END   = CNT_W'(crv_pkg::HEADER_BYTES);
    localparam logic [CNT_W-1:0] CRC_END   = CNT_W'(crv_pkg::CRC_BYTES);

    crv_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [CNT_W-1:0] count_reg, count_next, count_eff, count_inc;
    logic [31:0]      crc_reg, crc_next, crc_eff, crc_upd, crc_fin;
    logic [31:0]      word_reg, word_next, word_eff, word_upd;
    logic             magic_ok_reg, magic_ok_next, magic_ok_eff;
    logic             old_reg, old_next, old_eff;
    logic [CNT_W-1:0] pay_len;

    logic             emit;
    logic [1:0]       verdict_next;
    logic [31:0]      res_crc_next;

    logic             m_valid_reg;
    logic [1:0]       m_verdict_reg;
    logic [31:0]      m_crc_reg;

    // Advance unless this byte gives a verdict while an earlier one still waits
    assign item_take     = item_valid && (!emit || !m_valid_reg || m_ready);
    assign m_valid       = m_valid_reg;
    assign m_verdict     = m_verdict_reg;
    assign m_payload_crc = m_crc_reg;

    // Start flag restarts the check at this byte
    always_comb begin
        if (item.record_start) begin
            phase_eff    = crv_pkg::PH_HEADER;
            count_eff    = '0;
            crc_eff      = crv_pkg::CRC_INIT;
            word_eff     = '0;
            magic_ok_eff = 1'b0;
            old_eff      = 1'b0;
        end else begin
            phase_eff    = phase_reg;
            count_eff    = count_reg;
            crc_eff      = crc_reg;
            word_eff     = word_reg;
            magic_ok_eff = magic_ok_reg;
            old_eff      = old_reg;
        end
    end

    assign count_inc = count_eff + CNT_W'(1);
    assign word_upd  = word_eff | ({24'd0, item.record_byte} << {count_eff[1:0], 3'b000});
    assign crc_upd   = crv_pkg::crc32_byte(crc_eff, item.record_byte);
    assign crc_fin   = ~crc_eff;
    assign pay_len   = old_eff ? OLD_LEN : CUR_LEN;

    // Next state and verdict
    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        word_next     = word_reg;
        magic_ok_next = magic_ok_reg;
        old_next      = old_reg;
        emit          = 1'b0;
        verdict_next  = crv_pkg::VERDICT_DEFAULTS;
        res_crc_next  = '0;
        if (item_valid) begin
            phase_next    = phase_eff;
            count_next    = count_eff;
            crc_next      = crc_eff;
            word_next     = word_eff;
            magic_ok_next = magic_ok_eff;
            old_next      = old_eff;
            unique case (phase_eff)
                crv_pkg::PH_IDLE: ;
                crv_pkg::PH_HEADER: begin
                    word_next  = word_upd;
                    count_next = count_inc;
                    if (count_inc == MAGIC_END) begin
                        if (word_upd != cfg.record_magic) begin
                            emit       = 1'b1;
                            phase_next = crv_pkg::PH_IDLE;
                        end else begin
                            magic_ok_next = 1'b1;
                            word_next     = '0;
                        end
                    end else if (count_inc >= HDR_END) begin
                        if (word_upd == cfg.current_version) begin
                            old_next   = 1'b0;
                            word_next  = '0;
                            count_next = '0;
                            phase_next = crv_pkg::PH_PAYLOAD;
                        end else if (word_upd == crv_pkg::OLD_VERSION) begin
                            old_next   = 1'b1;
                            word_next  = '0;
                            count_next = '0;
                            phase_next = crv_pkg::PH_PAYLOAD;
                        end else begin
                            emit       = 1'b1;
                            phase_next = crv_pkg::PH_IDLE;
                        end
                    end
                end
                crv_pkg::PH_PAYLOAD: begin
                    crc_next   = crc_upd;
                    count_next = count_inc;
                    if (count_inc >= pay_len) begin
                        count_next = '0;
                        word_next  = '0;
                        phase_next = crv_pkg::PH_CRC;
                    end
                end
                crv_pkg::PH_CRC: begin
                    word_next  = word_upd;
                    count_next = count_inc;
                    if (count_inc >= CRC_END) begin
                        emit         = 1'b1;
                        phase_next   = crv_pkg::PH_IDLE;
                        res_crc_next = crc_fin;
                        if (magic_ok_eff && (crc_fin == word_upd)) begin
                            verdict_next = old_eff ? crv_pkg::VERDICT_MIGRATE
                                                   : crv_pkg::VERDICT_CURRENT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= crv_pkg::PH_IDLE;
            count_reg    <= '0;
            crc_reg      <= crv_pkg::CRC_INIT;
            word_reg     <= '0;
            magic_ok_reg <= 1'b0;
            old_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (item_take) begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                crc_reg      <= crc_next;
                word_reg     <= word_next;
                magic_ok_reg <= magic_ok_next;
                old_reg      <= old_next;
            end
            if (item_take && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            m_verdict_reg <= verdict_next;
            m_crc_reg     <= res_crc_next;
        end
    end

    // A verdict always closes the record
    `CRV_ASSERT_NEXT(a_emit_idles, aclk, aresetn, item_take && emit, phase_reg == crv_pkg::PH_IDLE)
    // A result appears only from a checked byte or a stalled earlier result
    `CRV_ASSERT_NEXT(a_no_phantom, aclk, aresetn, !(item_take && emit) && !(m_valid_reg && !m_ready), !m_valid_reg)
    // Payload count stays inside the selected layout
    `CRV_ASSERT_IMPLY(a_pay_count, aclk, aresetn, phase_reg == crv_pkg::PH_PAYLOAD, count_reg < (old_reg ? OLD_LEN : CUR_LEN))

endmodule

### design/calib_record_validator.sv
// A verdict is registered as the checker takes its deciding byte from the input stage.
// Throughput: one record byte per cycle, the byte-wide CRC update sitting in a single stage;
// a verdict byte stalls while an earlier verdict waits on m_ready, other bytes keep flowing.
// Reset (aresetn low, synchronous) returns to idle, waiting for a start byte,
// and loads record_magic = 0 and current_version = 2.
// ----------------------------------------------------------------------------
// Calibration record validator
// Checks magic, version and CRC-32 of a streamed calibration record.
// ----------------------------------------------------------------------------
module calib_record_validator #(
    parameter int CURRENT_PAYLOAD_BYTES = crv_pkg::CURRENT_PAYLOAD_BYTES,
    parameter int OLD_PAYLOAD_BYTES     = crv_pkg::OLD_PAYLOAD_BYTES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [crv_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_record_byte,
    input  logic                       s_record_start,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_verdict,
    output logic [31:0]                m_payload_crc
);

    crv_pkg::cfg_t  cfg;
    crv_pkg::item_t item;
    logic           item_valid;
    logic           item_take;

    crv_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crv_input_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_record_byte  (s_record_byte),
        .s_record_start (s_record_start),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take)
    );

    crv_record_check #(
        .CURRENT_PAYLOAD_BYTES (CURRENT_PAYLOAD_BYTES),
        .OLD_PAYLOAD_BYTES     (OLD_PAYLOAD_BYTES)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_payload_crc (m_payload_crc)
    );

endmodule
